FILE: hdl/fpc_pkg.sv
package fpc_pkg;

	localparam int DEF_NUM_PLANES = 6;
	localparam int DEF_FRAC_BITS  = 16;

	localparam int COORD_W  = 32;
	localparam int RADIUS_W = 31;
	localparam int PLANE_W  = 3;
	localparam int COEF_W   = 2;
	localparam int KIND_W   = 3;
	localparam int PROD_W   = 2 * COORD_W;
	// Three full products plus the shifted offset and radius term fit in 66 bits signed
	// for every fraction width up to 24.
	localparam int ACC_W    = PROD_W + 2;
	localparam int CORNERS  = 8;

	// Slave tdata layout, lowest bit first
	localparam int PLANE_LSB  = 0;
	localparam int COEF_LSB   = PLANE_LSB + PLANE_W;
	localparam int VALUE_LSB  = COEF_LSB + COEF_W;
	localparam int XL_LSB     = VALUE_LSB + COORD_W;
	localparam int YL_LSB     = XL_LSB + COORD_W;
	localparam int ZL_LSB     = YL_LSB + COORD_W;
	localparam int XH_LSB     = ZL_LSB + COORD_W;
	localparam int YH_LSB     = XH_LSB + COORD_W;
	localparam int ZH_LSB     = YH_LSB + COORD_W;
	localparam int RADIUS_LSB = ZH_LSB + COORD_W;
	localparam int IN_USED_W  = RADIUS_LSB + RADIUS_W;
	localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 8;

	typedef enum logic [KIND_W-1:0] {
		KIND_WRITE    = 3'd0,
		KIND_POINT    = 3'd1,
		KIND_SPHERE   = 3'd2,
		KIND_BOX_ANY  = 3'd3,
		KIND_BOX_FULL = 3'd4
	} kind_t;

	typedef enum logic [COEF_W-1:0] {
		COEF_A = 2'd0,
		COEF_B = 2'd1,
		COEF_C = 2'd2,
		COEF_D = 2'd3
	} coef_sel_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] a;
		logic signed [COORD_W-1:0] b;
		logic signed [COORD_W-1:0] c;
		logic signed [COORD_W-1:0] d;
	} plane_t;

	typedef struct packed {
		logic                      en;
		logic [PLANE_W-1:0]        plane;
		coef_sel_t                 coef;
		logic signed [COORD_W-1:0] data;
	} coef_wr_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] xl;
		logic signed [COORD_W-1:0] yl;
		logic signed [COORD_W-1:0] zl;
		logic signed [COORD_W-1:0] xh;
		logic signed [COORD_W-1:0] yh;
		logic signed [COORD_W-1:0] zh;
		logic signed [ACC_W-1:0]   bias;
	} shape_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

endpackage

FILE: hdl/fpc_plane_table.sv
module fpc_plane_table #(
	parameter int NUM_PLANES = fpc_pkg::DEF_NUM_PLANES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fpc_pkg::coef_wr_t wr,
	output fpc_pkg::plane_t  planes [NUM_PLANES]
);
	import fpc_pkg::*;

	plane_t planes_q [NUM_PLANES];

	// Out-of-range plane numbers match no entry and are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				planes_q[p] <= '0;
			end
		end else if (wr.en) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				if (wr.plane == PLANE_W'(p)) begin
					unique case (wr.coef)
						COEF_A: planes_q[p].a <= wr.data;
						COEF_B: planes_q[p].b <= wr.data;
						COEF_C: planes_q[p].c <= wr.data;
						COEF_D: planes_q[p].d <= wr.data;
					endcase
				end
			end
		end
	end

	assign planes = planes_q;

endmodule

FILE: hdl/fpc_plane_lane.sv
module fpc_plane_lane #(
	parameter int FRAC_BITS = fpc_pkg::DEF_FRAC_BITS
) (
	input  logic                         clk,
	input  fpc_pkg::pipe_en_t            en,
	input  fpc_pkg::plane_t              coef,
	input  fpc_pkg::shape_t              shape,
	output logic [fpc_pkg::CORNERS-1:0]  pos_s4
);
	import fpc_pkg::*;

	logic signed [PROD_W-1:0] pxl_s2, pxh_s2, pyl_s2, pyh_s2, pzl_s2, pzh_s2;
	logic signed [ACC_W-1:0]  dbias_s2;
	logic signed [ACC_W-1:0]  xy_s3 [4];
	logic signed [ACC_W-1:0]  zd_s3 [2];
	logic signed [ACC_W-1:0]  corner_sum [CORNERS];

	// Stage 2: one product per coefficient and coordinate choice
	always_ff @(posedge clk) begin
		if (en.s2) begin
			pxl_s2   <= coef.a * shape.xl;
			pxh_s2   <= coef.a * shape.xh;
			pyl_s2   <= coef.b * shape.yl;
			pyh_s2   <= coef.b * shape.yh;
			pzl_s2   <= coef.c * shape.zl;
			pzh_s2   <= coef.c * shape.zh;
			dbias_s2 <= (ACC_W'(coef.d) <<< FRAC_BITS) + shape.bias;
		end
	end

	// Stage 3: x+y partials for four corner pairs, z+offset for two
	always_ff @(posedge clk) begin
		if (en.s3) begin
			xy_s3[0] <= ACC_W'(pxl_s2) + ACC_W'(pyl_s2);
			xy_s3[1] <= ACC_W'(pxh_s2) + ACC_W'(pyl_s2);
			xy_s3[2] <= ACC_W'(pxl_s2) + ACC_W'(pyh_s2);
			xy_s3[3] <= ACC_W'(pxh_s2) + ACC_W'(pyh_s2);
			zd_s3[0] <= ACC_W'(pzl_s2) + dbias_s2;
			zd_s3[1] <= ACC_W'(pzh_s2) + dbias_s2;
		end
	end

	// Corner k: bit 0 picks x high, bit 1 y high, bit 2 z high
	always_comb begin
		for (int k = 0; k < CORNERS; k++) begin
			corner_sum[k] = xy_s3[k % 4] + zd_s3[k / 4];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			for (int k = 0; k < CORNERS; k++) begin
				pos_s4[k] <= !corner_sum[k][ACC_W-1] && (corner_sum[k] != '0);
			end
		end
	end

endmodule

FILE: hdl/frustum_plane_culling_top.sv
// Six-plane frustum culling pipeline. Every input transaction carries a kind in
// s_axis_tuser: a coefficient write loads one word of the plane table and produces no
// result, while a point, sphere, box-any or box-full test produces one inside flag on
// m_axis_tdata bit 0. Unused kinds are dropped without a result. The block accepts one
// transaction per cycle while not back-pressured; a test result passes through the
// input register, multiply, partial sums, corner sums and sign test, and plane
// reduction into the output register. A coefficient write takes effect at the edge it
// is accepted, so it applies to every test accepted after it and to none before it. The
// plane table resets to zero, so every test but a sphere with a nonzero radius answers
// 0 until planes are loaded. A stall on the master side fills pipeline bubbles first
// and back-pressures the slave side only once every stage holds a test.
module frustum_plane_culling_top #(
	parameter int NUM_PLANES = fpc_pkg::DEF_NUM_PLANES,
	parameter int FRAC_BITS  = fpc_pkg::DEF_FRAC_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// plane_index, coef_index, coef_value, x_low, y_low, z_low, x_high, y_high, z_high,
	// radius, zero pad
	input  logic [fpc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// kind
	input  logic [fpc_pkg::KIND_W-1:0]       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// inside_res, zero pad
	output logic [fpc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import fpc_pkg::*;

	kind_t    in_kind;
	logic     in_is_test;
	logic     in_accept;
	coef_wr_t wr;
	shape_t   in_shape;

	logic   rdy1, rdy2, rdy3, rdy4, rdy5;
	logic   valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	kind_t  kind_s1, kind_s2, kind_s3, kind_s4;
	shape_t shape_s1;
	logic   res_s5;
	logic   inside_s4;

	pipe_en_t                en;
	plane_t                  planes [NUM_PLANES];
	logic [CORNERS-1:0]      pos_s4 [NUM_PLANES];

	assign in_kind   = kind_t'(s_axis_tuser);
	assign in_accept = s_axis_tvalid && s_axis_tready;

	always_comb begin
		unique case (in_kind)
			KIND_POINT, KIND_SPHERE, KIND_BOX_ANY, KIND_BOX_FULL: in_is_test = 1'b1;
			default:                                              in_is_test = 1'b0;
		endcase
	end

	// Coefficient write transaction goes straight to the table
	assign wr.en    = in_accept && (in_kind == KIND_WRITE);
	assign wr.plane = s_axis_tdata[PLANE_LSB +: PLANE_W];
	assign wr.coef  = coef_sel_t'(s_axis_tdata[COEF_LSB +: COEF_W]);
	assign wr.data  = s_axis_tdata[VALUE_LSB +: COORD_W];

	// Unpack geometry; the radius becomes a bias at the product's fraction width
	always_comb begin
		in_shape.xl = s_axis_tdata[XL_LSB +: COORD_W];
		in_shape.yl = s_axis_tdata[YL_LSB +: COORD_W];
		in_shape.zl = s_axis_tdata[ZL_LSB +: COORD_W];
		in_shape.xh = s_axis_tdata[XH_LSB +: COORD_W];
		in_shape.yh = s_axis_tdata[YH_LSB +: COORD_W];
		in_shape.zh = s_axis_tdata[ZH_LSB +: COORD_W];
		if (in_kind == KIND_SPHERE) begin
			in_shape.bias = ACC_W'(s_axis_tdata[RADIUS_LSB +: RADIUS_W]) << FRAC_BITS;
		end else begin
			in_shape.bias = '0;
		end
	end

	// Per-stage ready: a stage advances when empty or when the next one advances
	assign rdy5 = !valid_s5 || m_axis_tready;
	assign rdy4 = !valid_s4 || rdy5;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign s_axis_tready = rdy1;

	assign en.s2 = rdy2;
	assign en.s3 = rdy3;
	assign en.s4 = rdy4;

	// Valid bits; only test transactions occupy the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= s_axis_tvalid && in_is_test;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
		end
	end

	// Payload: hold while the stage is stalled
	always_ff @(posedge clk) begin
		if (rdy1) begin
			kind_s1  <= in_kind;
			shape_s1 <= in_shape;
		end
		if (rdy2) kind_s2 <= kind_s1;
		if (rdy3) kind_s3 <= kind_s2;
		if (rdy4) kind_s4 <= kind_s3;
		if (rdy5) res_s5 <= inside_s4;
	end

	fpc_plane_table #(
		.NUM_PLANES (NUM_PLANES)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.planes (planes)
	);

	// One lane per plane; the table is read as the test leaves stage 1
	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
		fpc_plane_lane #(
			.FRAC_BITS (FRAC_BITS)
		) u_lane (
			.clk    (clk),
			.en     (en),
			.coef   (planes[p]),
			.shape  (shape_s1),
			.pos_s4 (pos_s4[p])
		);
	end

	// Reduce corner signs over planes; point and sphere use the low corner only
	always_comb begin
		inside_s4 = 1'b1;
		for (int p = 0; p < NUM_PLANES; p++) begin
			unique case (kind_s4)
				KIND_POINT, KIND_SPHERE: if (!pos_s4[p][0]) inside_s4 = 1'b0;
				KIND_BOX_ANY:            if (pos_s4[p] == '0) inside_s4 = 1'b0;
				KIND_BOX_FULL:           if (!(&pos_s4[p])) inside_s4 = 1'b0;
				default:                 inside_s4 = 1'b0;
			endcase
		end
	end

	assign m_axis_tvalid = valid_s5;
	assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, res_s5};

endmodule

FILE: tb/sv/frustum_plane_culling_top_tb.sv
module frustum_plane_culling_top_tb;
	import fpc_pkg::*;

	localparam int NUM_PLANES    = DEF_NUM_PLANES;
	localparam int FRAC_BITS     = DEF_FRAC_BITS;
	localparam int TBL_WORDS     = NUM_PLANES * 4;
	localparam int RANDOM_ITEMS  = 300;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 20;
	localparam int MAX_REPORTS   = 10;
	localparam int TX_SIDE       = 0;
	localparam int RX_SIDE       = 1;

	// 1.0 in Q16.16
	localparam logic signed [COORD_W-1:0] ONE   = 32'sh0001_0000;
	localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;
	localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
	localparam logic [RADIUS_W-1:0]       R_MAX = 31'h7fff_ffff;

	// One slave-side transaction as the stimulus sees it. The kind is kept as a raw
	// 3-bit value so that the unused kinds can be sent too.
	typedef struct {
		logic [KIND_W-1:0]         kind;
		logic [PLANE_W-1:0]        plane;
		logic [COEF_W-1:0]         coef;
		logic signed [COORD_W-1:0] value;
		logic signed [COORD_W-1:0] xl, yl, zl;
		logic signed [COORD_W-1:0] xh, yh, zh;
		logic [RADIUS_W-1:0]       radius;
		bit                        drain;
	} cull_item_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
	logic [KIND_W-1:0]       s_axis_tuser = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;

	// Private copy of the plane table, updated as writes are accepted
	logic signed [COORD_W-1:0] coef_tbl [TBL_WORDS] = '{default: '0};

	cull_item_t  pending_items[$];
	logic        inside_due[$];
	cull_item_t  cur_item;
	cull_item_t  next_item;
	int unsigned calm_run [2] = '{0, 0};
	int unsigned tx_gap = 0;
	int unsigned rx_stall = 0;
	int unsigned hold_left = 0;
	int unsigned items_accepted = 0;
	int unsigned total_items = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	logic        want_inside;

	frustum_plane_culling_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		// plane_index, coef_index, coef_value, x_low, y_low, z_low, x_high, y_high,
		// z_high, radius, zero pad
		.s_axis_tdata  (s_axis_tdata),
		// kind
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		// inside_res, zero pad
		.m_axis_tdata  (m_axis_tdata)
	);

	initial forever #1 clk = ~clk;

	// Exact plane value a*x+b*y+c*z+d+bias at twice the fraction width; wide enough
	// that nothing wraps. True when strictly positive.
	function automatic logic plane_clear(int p, logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z,
			logic signed [127:0] bias);
		logic signed [127:0] acc;
		acc = bias;
		acc = acc + longint'(coef_tbl[p*4 + int'(COEF_A)]) * longint'(x);
		acc = acc + longint'(coef_tbl[p*4 + int'(COEF_B)]) * longint'(y);
		acc = acc + longint'(coef_tbl[p*4 + int'(COEF_C)]) * longint'(z);
		acc = acc + (longint'(coef_tbl[p*4 + int'(COEF_D)]) <<< FRAC_BITS);
		return acc > 0;
	endfunction

	// Apply one accepted transaction: load the table or queue the expected inside flag
	function automatic void predict_cull(cull_item_t it);
		logic signed [127:0]       bias;
		logic                      inside_exp;
		logic                      any_pos;
		logic                      all_pos;
		logic                      pos;
		logic signed [COORD_W-1:0] cx, cy, cz;
		if (it.kind == KIND_WRITE) begin
			// writes beyond the last plane are dropped
			if (it.plane < NUM_PLANES) begin
				coef_tbl[it.plane*4 + it.coef] = it.value;
			end
			return;
		end
		if (it.kind > KIND_BOX_FULL) begin
			return;
		end
		inside_exp = 1'b1;
		bias = '0;
		if (it.kind == KIND_SPHERE) begin
			bias = longint'(it.radius) <<< FRAC_BITS;
		end
		for (int p = 0; p < NUM_PLANES; p++) begin
			if (it.kind == KIND_POINT || it.kind == KIND_SPHERE) begin
				if (!plane_clear(p, it.xl, it.yl, it.zl, bias)) begin
					inside_exp = 1'b0;
				end
			end else begin
				any_pos = 1'b0;
				all_pos = 1'b1;
				// corners taken as given, low and high need not be ordered
				for (int k = 0; k < CORNERS; k++) begin
					cx = k[0] ? it.xh : it.xl;
					cy = k[1] ? it.yh : it.yl;
					cz = k[2] ? it.zh : it.zl;
					pos = plane_clear(p, cx, cy, cz, '0);
					any_pos = any_pos | pos;
					all_pos = all_pos & pos;
				end
				if (it.kind == KIND_BOX_ANY ? !any_pos : !all_pos) begin
					inside_exp = 1'b0;
				end
			end
		end
		inside_due.push_back(inside_exp);
	endfunction

	// Idle length for one side: mostly short, a few long, and now and then a run
	// of items with no idling at all
	function automatic int unsigned pick_gap(int side);
		int unsigned roll;
		if (calm_run[side] != 0) begin
			calm_run[side]--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			calm_run[side] = $urandom_range(20, 60);
			return 0;
		end
		if (roll < 50) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord(int unsigned span);
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 7) return int'($urandom_range(0, 2*span)) - int'(span);
		if (roll < 9) return $urandom;
		case ($urandom_range(0, 3))
			0: return C_MAX;
			1: return C_MIN;
			2: return 32'sd0;
			default: return -32'sd1;
		endcase
	endfunction

	function automatic logic [RADIUS_W-1:0] rand_radius(int unsigned span);
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 7) return RADIUS_W'($urandom_range(0, 2*span));
		if (roll < 9) return RADIUS_W'($urandom);
		return roll[0] ? R_MAX : '0;
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coef_value();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 6) return int'($urandom_range(0, 4*ONE)) - int'(2*ONE);
		if (roll < 8) return $urandom;
		return roll[0] ? C_MAX : C_MIN;
	endfunction

	// Coefficient write; fields a write ignores carry noise
	function automatic cull_item_t coef_write(int plane, int coef,
			logic signed [COORD_W-1:0] value);
		cull_item_t it;
		it.kind   = KIND_WRITE;
		it.plane  = PLANE_W'(plane);
		it.coef   = COEF_W'(coef);
		it.value  = value;
		it.xl     = $urandom;
		it.yl     = $urandom;
		it.zl     = $urandom;
		it.xh     = $urandom;
		it.yh     = $urandom;
		it.zh     = $urandom;
		it.radius = RADIUS_W'($urandom);
		it.drain  = 1'b0;
		return it;
	endfunction

	// Shape test; the write fields carry noise
	function automatic cull_item_t shape_test(logic [KIND_W-1:0] kind,
			logic signed [COORD_W-1:0] xl, logic signed [COORD_W-1:0] yl,
			logic signed [COORD_W-1:0] zl, logic signed [COORD_W-1:0] xh,
			logic signed [COORD_W-1:0] yh, logic signed [COORD_W-1:0] zh,
			logic [RADIUS_W-1:0] radius);
		cull_item_t it;
		it.kind   = kind;
		it.plane  = PLANE_W'($urandom);
		it.coef   = COEF_W'($urandom);
		it.value  = $urandom;
		it.xl     = xl;
		it.yl     = yl;
		it.zl     = zl;
		it.xh     = xh;
		it.yh     = yh;
		it.zh     = zh;
		it.radius = radius;
		it.drain  = 1'b0;
		return it;
	endfunction

	// Queue an axis-aligned cube of half size 'half', each of a, b and c nudged by up
	// to +/-tilt. Skip zero words only when the table is known to be clear.
	task automatic push_frustum(int unsigned half, int unsigned tilt, bit all_words);
		logic signed [COORD_W-1:0] w;
		for (int p = 0; p < NUM_PLANES; p++) begin
			for (int c = int'(COEF_A); c <= int'(COEF_C); c++) begin
				w = (c == p/2) ? ((p%2 == 0) ? ONE : -ONE) : 32'sd0;
				if (tilt != 0) begin
					w = w + (int'($urandom_range(0, 2*tilt)) - int'(tilt));
				end
				if (all_words || w != 0) begin
					pending_items.push_back(coef_write(p, c, w));
				end
			end
			pending_items.push_back(coef_write(p, COEF_D, half));
		end
	endtask

	// Stimulus and end of run
	initial begin
		int unsigned half;
		int unsigned span;
		int unsigned roll;
		bit          near_box;
		logic signed [COORD_W-1:0] xl, yl, zl;

		// Empty table: a point test answers 0
		pending_items.push_back(shape_test(KIND_POINT, 0, 0, 0, 0, 0, 0, 0));
		// Cube of half size 2.0 around the origin
		push_frustum(2*ONE, 0, 1'b0);
		pending_items.push_back(shape_test(KIND_POINT, 0, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(shape_test(KIND_POINT, 3*ONE, 0, 0, 0, 0, 0, 0));
		// On a face: value exactly zero is outside
		pending_items.push_back(shape_test(KIND_POINT, 2*ONE, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(shape_test(KIND_SPHERE, 5*ONE/2, 0, 0, 0, 0, 0, ONE));
		pending_items.push_back(shape_test(KIND_SPHERE, 5*ONE/2, 0, 0, 0, 0, 0, ONE/4));
		pending_items.push_back(shape_test(KIND_SPHERE, C_MAX, C_MIN, C_MAX, 0, 0, 0, R_MAX));
		pending_items.push_back(shape_test(KIND_BOX_ANY, ONE, -ONE, -ONE,
			3*ONE, ONE, ONE, 0));
		pending_items.push_back(shape_test(KIND_BOX_FULL, ONE, -ONE, -ONE,
			3*ONE, ONE, ONE, 0));
		// Corners given high first
		pending_items.push_back(shape_test(KIND_BOX_FULL, ONE, ONE, ONE,
			-ONE, -ONE, -ONE, 0));
		pending_items.push_back(shape_test(KIND_BOX_ANY, 3*ONE, 3*ONE, 3*ONE,
			4*ONE, 4*ONE, 4*ONE, 0));
		pending_items.push_back(shape_test(KIND_BOX_ANY, C_MIN, C_MIN, C_MIN,
			C_MAX, C_MAX, C_MAX, 0));
		pending_items.push_back(shape_test(KIND_POINT, C_MAX, C_MAX, C_MAX, 0, 0, 0, 0));
		// Writes past the last plane must leave the table alone
		pending_items.push_back(coef_write(NUM_PLANES, COEF_D, C_MIN));
		pending_items.push_back(coef_write(7, COEF_A, C_MIN));
		pending_items.push_back(shape_test(KIND_POINT, 0, 0, 0, 0, 0, 0, 0));
		// Unused kinds: no result
		for (int k = int'(KIND_BOX_FULL) + 1; k < (1 << KIND_W); k++) begin
			pending_items.push_back(shape_test(KIND_W'(k), $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, RADIUS_W'($urandom)));
		end
		// Most negative coefficient times most negative coordinate
		pending_items.push_back(coef_write(0, COEF_A, C_MIN));
		pending_items.push_back(shape_test(KIND_POINT, C_MIN, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(shape_test(KIND_BOX_FULL, C_MIN, 0, 0, C_MAX, ONE, ONE, 0));
		pending_items.push_back(coef_write(0, COEF_A, ONE));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Reload a fresh frustum now and then so tests keep landing on both sides
			if (n % 100 == 0) begin
				half = $urandom_range(ONE/4, 8*ONE);
				push_frustum(half, $urandom_range(0, 1) ? $urandom_range(1, ONE/4) : 0, 1'b1);
			end
			span = 3 * half / 2;
			roll = $urandom_range(0, 99);
			if (roll < 10) begin
				pending_items.push_back(coef_write($urandom_range(0, 7), $urandom_range(0, 3),
					rand_coef_value()));
			end else if (roll < 13) begin
				pending_items.push_back(shape_test(KIND_W'($urandom_range(int'(KIND_BOX_FULL) + 1,
					(1 << KIND_W) - 1)), $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, RADIUS_W'($urandom)));
			end else begin
				xl = rand_coord(span);
				yl = rand_coord(span);
				zl = rand_coord(span);
				near_box = $urandom_range(0, 1);
				pending_items.push_back(shape_test(KIND_W'($urandom_range(int'(KIND_POINT),
					int'(KIND_BOX_FULL))), xl, yl, zl,
					near_box ? xl + int'($urandom_range(0, half)) : rand_coord(span),
					near_box ? yl + int'($urandom_range(0, half)) : rand_coord(span),
					near_box ? zl + int'($urandom_range(0, half)) : rand_coord(span),
					rand_radius(span)));
			end
			// Hold the sender until every outstanding result is back
			if (n == 0 || n == RANDOM_ITEMS/2) begin
				pending_items[$].drain = 1'b1;
			end
		end
		total_items = pending_items.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (items_accepted != total_items) @(posedge clk);
		while (inside_due.size() != 0) @(posedge clk);
		// Catch any stray result after the last expected one
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && inside_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Driver: predict on each accepted transaction, then present the next one after
	// a random gap. A drain-marked item waits until nothing is outstanding.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
			tx_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_cull(cur_item);
				items_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap != 0) begin
					tx_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_items.size() != 0 &&
						!(pending_items[0].drain && inside_due.size() != 0)) begin
					next_item = pending_items.pop_front();
					cur_item = next_item;
					s_axis_tuser  <= next_item.kind;
					s_axis_tdata  <= IN_TDATA_W'({next_item.radius, next_item.zh, next_item.yh,
						next_item.xh, next_item.zl, next_item.yl, next_item.xl,
						next_item.value, next_item.coef, next_item.plane});
					s_axis_tvalid <= 1'b1;
					tx_gap = pick_gap(TX_SIDE);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transaction against the oldest expectation, and
	// stall the master side at random. Twice in the run, hold off for a long
	// stretch so the pipeline fills and back-pressures the sender.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_stall = 0;
			hold_left = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (inside_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("unexpected result transaction: inside_res=%0b", m_axis_tdata[0]);
					end
				end else begin
					want_inside = inside_due.pop_front();
					if (m_axis_tdata[0] !== want_inside) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("inside_res mismatch on result %0d: expected %0b, actual %0b",
								results_seen, want_inside, m_axis_tdata[0]);
						end
					end
				end
				results_seen++;
				if (results_seen == 40 || results_seen == 150) begin
					hold_left = HOLD_CYCLES;
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (rx_stall != 0) begin
				rx_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				rx_stall = pick_gap(RX_SIDE);
			end
		end
	end

	// Watchdog: end a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

endmodule

FILE: files.f
hdl/fpc_pkg.sv
hdl/fpc_plane_table.sv
hdl/fpc_plane_lane.sv
hdl/frustum_plane_culling_top.sv
tb/sv/frustum_plane_culling_top_tb.sv
